>>> src/scp_pkg.sv
// package: geometry constants, result codes and shared types of the sector request planner
`timescale 1ns / 1ps

package scp_pkg;

  // disk geometry
  localparam int SECTORS_PER_TRACK = 18;
  localparam int HEAD_COUNT        = 2;
  localparam int TOTAL_SECTORS     = 2880;
  localparam int SECTOR_BYTES      = 512;
  localparam int MAX_RUN           = 64;

  localparam int PER_CYL      = SECTORS_PER_TRACK * HEAD_COUNT;
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int LBA_W        = $clog2(TOTAL_SECTORS);
  localparam int IDX_W        = $clog2(PER_CYL);
  localparam int CNT_W        = $clog2(MAX_RUN + 1);

  // reciprocal of sectors per cylinder, exact for every lba below 2**LBA_W
  localparam int RECIP_SHIFT = LBA_W + IDX_W;
  localparam int RECIP_MULT  = ((2 ** RECIP_SHIFT) + PER_CYL - 1) / PER_CYL;

  // result field widths
  localparam int STATUS_W = 3;
  localparam int CYL_W    = 7;
  localparam int SEC_W    = 5;
  localparam int BOFF_W   = 15;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_READ_ONLY  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_OFFSET = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_LENGTH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd4;

  typedef struct packed {
    logic        is_write;
    logic [31:0] byte_offset;
    logic [31:0] byte_length;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CYL_W-1:0]    cylinder_number;
    logic                head_number;
    logic [SEC_W-1:0]    sector_number;
    logic [BOFF_W-1:0]   buffer_offset;
    logic                from_zero_copy;
    logic                fetch_needed;
    logic                save_zero_copy;
    logic                last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take the request into the request register
    logic div_start; // load the start cylinder and the sector count
    logic div_step;  // load the sector index inside the start cylinder
    logic emit;      // load one sector result and advance
    logic err_load;  // load the single error result
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [STATUS_W-1:0] status;      // outcome of the request checks
    logic                last_sector; // the sector about to go out ends the run
    logic                out_free;    // output register can take a result
  } ctl_sts_t;

endpackage

>>> src/scp_ctrl.sv
// controller: request sequencing state machine
`timescale 1ns / 1ps

module scp_ctrl import scp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ERROR,
    S_DIVIDE,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic                in_stall_r;

  assign in_stall = in_stall_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall_r) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.status != ST_OK) begin
          state_nxt = S_ERROR;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVIDE;
        end
      end
      S_ERROR: begin
        if (sts.out_free) begin
          cmd.err_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_sector) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

endmodule

>>> src/scp_datapath.sv
// datapath: request checks, lba divider, sector walk, cache tracking and output register
`timescale 1ns / 1ps

module scp_datapath import scp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  ctl_cmd_t  cmd,
  output ctl_sts_t  sts,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_stall
);

  in_item_t          req_r;
  logic [LBA_W-1:0]  quo_r;   // cylinder of the current sector
  logic [IDX_W-1:0]  rem_r;   // sector index inside the cylinder
  logic [CNT_W-1:0]  left_r;
  logic [CYL_W-1:0]  cached_cyl_r;
  logic              cache_valid_r;
  logic              zero_valid_r;
  logic              out_valid_r;
  out_item_t         out_r;

  // request checks
  logic [31:0]         lba_full, cnt_full;
  logic [32:0]         end_sum;
  logic [STATUS_W-1:0] status;

  always_comb begin
    lba_full = req_r.byte_offset >> SECTOR_SHIFT;
    cnt_full = req_r.byte_length >> SECTOR_SHIFT;
    end_sum  = {1'b0, lba_full} + {1'b0, cnt_full};
    if (req_r.is_write) begin
      status = ST_READ_ONLY;
    end else if ((req_r.byte_offset % SECTOR_BYTES) != 32'd0) begin
      status = ST_BAD_OFFSET;
    end else if ((req_r.byte_length % SECTOR_BYTES) != 32'd0) begin
      status = ST_BAD_LENGTH;
    end else if (cnt_full == 32'd0 || cnt_full > 32'(MAX_RUN) ||
                 lba_full >= 32'(TOTAL_SECTORS) || end_sum > 33'(TOTAL_SECTORS)) begin
      status = ST_RANGE;
    end else begin
      status = ST_OK;
    end
  end

  // start cylinder by reciprocal multiply, sector index by multiply and subtract next cycle
  logic [LBA_W+RECIP_SHIFT-1:0] recip_prod;
  logic [LBA_W-1:0]             cyl_quo;
  logic [IDX_W-1:0]             cyl_rem;

  always_comb begin
    recip_prod = (LBA_W+RECIP_SHIFT)'(lba_full[LBA_W-1:0]) *
                 (LBA_W+RECIP_SHIFT)'(RECIP_MULT);
    cyl_quo    = LBA_W'(recip_prod >> RECIP_SHIFT);
    cyl_rem    = IDX_W'(lba_full[LBA_W-1:0] - quo_r * LBA_W'(PER_CYL));
  end

  // current sector fields
  logic             head;
  logic [IDX_W-1:0] sec_idx;
  logic [CYL_W-1:0] cyl;
  logic             cyl_zero;
  logic             fetch;
  out_item_t        cur;
  out_item_t        err_item;

  always_comb begin
    head     = (rem_r >= IDX_W'(SECTORS_PER_TRACK));
    sec_idx  = head ? rem_r - IDX_W'(SECTORS_PER_TRACK) : rem_r;
    cyl      = CYL_W'(quo_r);
    cyl_zero = (cyl == '0);
    fetch    = cyl_zero ? !zero_valid_r : (!cache_valid_r || cached_cyl_r != cyl);
    cur                 = '0;
    cur.status          = ST_OK;
    cur.cylinder_number = cyl;
    cur.head_number     = head;
    cur.sector_number   = SEC_W'(sec_idx + 1'b1);
    cur.buffer_offset   = BOFF_W'(32'(rem_r) << SECTOR_SHIFT);
    cur.from_zero_copy  = cyl_zero;
    cur.fetch_needed    = fetch;
    cur.save_zero_copy  = cyl_zero && !zero_valid_r;
    cur.last            = (left_r == CNT_W'(1));
    err_item            = '0;
    err_item.status     = status;
    err_item.last       = 1'b1;
  end

  assign sts.status      = status;
  assign sts.last_sector = (left_r == CNT_W'(1));
  assign sts.out_free    = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_item;
    end
    if (cmd.div_start) begin
      quo_r  <= cyl_quo;
      rem_r  <= '0;
      left_r <= CNT_W'(cnt_full);
    end else if (cmd.div_step) begin
      rem_r <= cyl_rem;
    end else if (cmd.emit) begin
      left_r <= left_r - 1'b1;
      if (rem_r == IDX_W'(PER_CYL - 1)) begin
        rem_r <= '0;
        quo_r <= quo_r + 1'b1;
      end else begin
        rem_r <= rem_r + 1'b1;
      end
    end
    if (cmd.emit) begin
      out_r <= cur;
    end else if (cmd.err_load) begin
      out_r <= err_item;
    end
  end

  // cache tracking and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cached_cyl_r  <= '0;
      cache_valid_r <= 1'b0;
      zero_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.emit) begin
        if (cyl_zero) begin
          if (!zero_valid_r) begin
            zero_valid_r  <= 1'b1;
            cached_cyl_r  <= '0;
            cache_valid_r <= 1'b1;
          end
        end else begin
          cached_cyl_r  <= cyl;
          cache_valid_r <= 1'b1;
        end
      end
      if (cmd.emit || cmd.err_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> src/sector_request_chs_planner_core.sv
// top level: sector request planner, read-only floppy lba to cylinder/head/sector mapping
// a request is taken, then checked while a reciprocal multiply gives the start cylinder,
// then a multiply and subtract gives the sector index inside that cylinder
// the first sector item is loaded after the check and divide states, then one a cycle
// while the output is free (count <= 64); the input is stalled until the last is loaded;
// an error item is loaded once the output is free; reset empties the output and both caches
`timescale 1ns / 1ps

module sector_request_chs_planner_core import scp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  // request channel
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  // result channel
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // command and status between the sequencer and the datapath
  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // sequencer: idle, check, error or divide then emit one sector per free output slot
  scp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: checks, divider, sector walk, cache flags, output register
  scp_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

endmodule
